### sv/olist_pkg.sv
package olist_pkg;

  // Port field widths
  localparam int ACTION_W   = 3;
  localparam int POS_W      = 4;
  localparam int ITEM_W     = 32;
  localparam int FIDX_W     = 4;
  localparam int STATUS_W   = 2;
  localparam int ECOUNT_W   = 5;

  // Request actions
  localparam logic [ACTION_W-1:0] ACT_APPEND = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_DROP   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_READ   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_FIND   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd5;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_FULL  = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_FIND,
    S_REMOVE,
    S_INSERT,
    S_PLACE
  } state_t;

endpackage

### sv/ordered_list_engine_core.sv
// Bounded ordered list of up to DEPTH values in a single-port-read, single-port-write
// synchronous RAM plus an entry count. A request is taken when start is high and busy
// is low; its result appears on the out_ ports for one cycle, marked by out_valid, and
// must be captured then since the block cannot be stalled. Append, drop, unused actions
// and requests turned away for a bad position, an empty list or a full store give their
// result in the next cycle, as does insert into an empty list; a read passes through the
// RAM read register and then S_READ. Find, remove and insert walk the RAM one entry per
// cycle; find stops at the first match or after the last entry. busy drops during the
// strobe cycle, so the next request may be taken there.
module ordered_list_engine_core #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic        [olist_pkg::ACTION_W-1:0] in_action,
  input  logic        [olist_pkg::POS_W-1:0]    in_position,
  input  logic signed [olist_pkg::ITEM_W-1:0]   in_item_value,
  output logic                                  out_valid,
  output logic signed [olist_pkg::ITEM_W-1:0]   out_read_value,
  output logic                                  out_found_flag,
  output logic        [olist_pkg::FIDX_W-1:0]   out_found_index,
  output logic        [olist_pkg::STATUS_W-1:0] out_status,
  output logic        [olist_pkg::ECOUNT_W-1:0] out_entry_count
);
  import olist_pkg::*;

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int VW   = VALUE_WIDTH;
  localparam int XW   = (VW > ITEM_W) ? VW : ITEM_W;
  localparam int PCW  = (CW > POS_W) ? CW : POS_W;
  localparam int FXW  = (CW > FIDX_W) ? CW : FIDX_W;
  localparam int ECW  = (CW > ECOUNT_W) ? CW : ECOUNT_W;

  // Sequencer and list state
  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     ptr_r, ptr_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  logic [VW-1:0]     key_r, key_nxt;

  // Result registers
  logic              out_valid_r, out_valid_nxt;
  logic [ITEM_W-1:0] read_value_r, read_value_nxt;
  logic              found_flag_r, found_flag_nxt;
  logic [CW-1:0]     found_index_r, found_index_nxt;
  status_t           status_r, status_nxt;

  // RAM ports
  logic [VW-1:0]     entries_mem [DEPTH];
  logic [VW-1:0]     rd_data_r;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [VW-1:0]     mem_wdata;

  // Request decode
  logic [XW-1:0]     item_ext;
  logic [VW-1:0]     item_key;
  logic [PCW-1:0]    pos_cmp;
  logic [PCW-1:0]    cnt_cmp;
  logic [CW-1:0]     pos_in;
  logic              pos_ok;
  logic              list_full;
  logic              list_empty;
  logic [CW-1:0]     ptr_inc;
  logic [CW-1:0]     ptr_dec;
  logic [CW-1:0]     count_inc;
  logic [CW-1:0]     count_dec;
  logic [XW-1:0]     rd_sext;
  logic [FXW-1:0]    fidx_wide;
  logic [ECW-1:0]    ecount_wide;

  assign item_ext   = XW'($unsigned(in_item_value));
  assign item_key   = item_ext[VW-1:0];
  assign pos_cmp    = PCW'(in_position);
  assign cnt_cmp    = PCW'(count_r);
  assign pos_in     = pos_cmp[CW-1:0];
  assign pos_ok     = (pos_cmp < cnt_cmp);
  assign list_full  = (count_r == CW'(DEPTH));
  assign list_empty = (count_r == '0);
  assign ptr_inc    = CW'(ptr_r + 1'b1);
  assign ptr_dec    = CW'(ptr_r - 1'b1);
  assign count_inc  = CW'(count_r + 1'b1);
  assign count_dec  = CW'(count_r - 1'b1);
  assign rd_sext    = XW'($signed(rd_data_r));

  // RAM: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      entries_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= entries_mem[mem_raddr];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    ptr_r         <= ptr_nxt;
    pos_r         <= pos_nxt;
    key_r         <= key_nxt;
    read_value_r  <= read_value_nxt;
    found_flag_r  <= found_flag_nxt;
    found_index_r <= found_index_nxt;
    status_r      <= status_nxt;
  end

  // Sequencer: next state, RAM accesses and result
  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    ptr_nxt         = ptr_r;
    pos_nxt         = pos_r;
    key_nxt         = key_r;
    out_valid_nxt   = 1'b0;
    read_value_nxt  = '0;
    found_flag_nxt  = 1'b0;
    found_index_nxt = '0;
    status_nxt      = STAT_OK;
    mem_re          = 1'b0;
    mem_raddr       = '0;
    mem_we          = 1'b0;
    mem_waddr       = '0;
    mem_wdata       = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_action)
            ACT_APPEND: begin
              out_valid_nxt = 1'b1;
              if (list_full) begin
                status_nxt = STAT_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = count_r[AW-1:0];
                mem_wdata = item_key;
                count_nxt = count_inc;
              end
            end
            ACT_DROP: begin
              out_valid_nxt = 1'b1;
              if (list_empty) begin
                status_nxt = STAT_EMPTY;
              end else begin
                count_nxt = count_dec;
              end
            end
            ACT_READ: begin
              if (pos_ok) begin
                mem_re    = 1'b1;
                mem_raddr = pos_in[AW-1:0];
                state_nxt = S_READ;
              end else begin
                out_valid_nxt = 1'b1;
                status_nxt    = STAT_RANGE;
              end
            end
            ACT_FIND: begin
              if (list_empty) begin
                out_valid_nxt = 1'b1;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                ptr_nxt   = '0;
                key_nxt   = item_key;
                state_nxt = S_FIND;
              end
            end
            ACT_REMOVE: begin
              if (!pos_ok) begin
                out_valid_nxt = 1'b1;
                status_nxt    = STAT_RANGE;
              end else if (CW'(pos_in + 1'b1) == count_r) begin
                // tail entry: nothing to shift
                out_valid_nxt = 1'b1;
                count_nxt     = count_dec;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = AW'(pos_in + 1'b1);
                ptr_nxt   = CW'(pos_in + 1'b1);
                state_nxt = S_REMOVE;
              end
            end
            ACT_INSERT: begin
              if ((in_position != '0) && !pos_ok) begin
                out_valid_nxt = 1'b1;
                status_nxt    = STAT_RANGE;
              end else if (list_full) begin
                out_valid_nxt = 1'b1;
                status_nxt    = STAT_FULL;
              end else if (list_empty) begin
                out_valid_nxt = 1'b1;
                mem_we        = 1'b1;
                mem_waddr     = '0;
                mem_wdata     = item_key;
                count_nxt     = count_inc;
              end else begin
                // shift from the tail down to the insert point
                mem_re    = 1'b1;
                mem_raddr = count_dec[AW-1:0];
                ptr_nxt   = count_dec;
                pos_nxt   = pos_in;
                key_nxt   = item_key;
                state_nxt = S_INSERT;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      S_READ: begin
        out_valid_nxt  = 1'b1;
        read_value_nxt = rd_sext[ITEM_W-1:0];
        state_nxt      = S_IDLE;
      end

      // Compare one entry per cycle while fetching the next
      S_FIND: begin
        if (rd_data_r == key_r) begin
          out_valid_nxt   = 1'b1;
          found_flag_nxt  = 1'b1;
          found_index_nxt = ptr_r;
          state_nxt       = S_IDLE;
        end else if (ptr_inc == count_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr_inc[AW-1:0];
          ptr_nxt   = ptr_inc;
        end
      end

      // Move each later entry down by one
      S_REMOVE: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_dec[AW-1:0];
        mem_wdata = rd_data_r;
        if (ptr_inc == count_r) begin
          out_valid_nxt = 1'b1;
          count_nxt     = count_dec;
          state_nxt     = S_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr_inc[AW-1:0];
          ptr_nxt   = ptr_inc;
        end
      end

      // Move each entry from the insert point on up by one
      S_INSERT: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_inc[AW-1:0];
        mem_wdata = rd_data_r;
        if (ptr_r == pos_r) begin
          state_nxt = S_PLACE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr_dec[AW-1:0];
          ptr_nxt   = ptr_dec;
        end
      end

      // Drop the new value into the opened slot
      S_PLACE: begin
        mem_we        = 1'b1;
        mem_waddr     = pos_r[AW-1:0];
        mem_wdata     = key_r;
        count_nxt     = count_inc;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Drive result ports
  assign fidx_wide       = FXW'(found_index_r);
  assign ecount_wide     = ECW'(count_r);
  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_read_value  = $signed(read_value_r);
  assign out_found_flag  = found_flag_r;
  assign out_found_index = fidx_wide[FIDX_W-1:0];
  assign out_status      = status_r;
  assign out_entry_count = ecount_wide[ECOUNT_W-1:0];

endmodule
